// ----- design/hpt_pkg.sv -----
// Shared types, codes and constants of the heartbeat presence table.
`default_nettype none
package hpt_pkg;

	localparam int HPT_MAX_ENTRIES = 16;
	localparam int ID_W            = 22;
	localparam int STAMP_W         = 32;
	localparam int TMO_W           = 16;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd35;

	// result actions
	localparam logic [2:0] ACT_REFRESHED = 3'd0;
	localparam logic [2:0] ACT_ADDED     = 3'd1;
	localparam logic [2:0] ACT_REMOVED   = 3'd2;
	localparam logic [2:0] ACT_IGNORED   = 3'd3;
	localparam logic [2:0] ACT_REFUSED   = 3'd4;
	localparam logic [2:0] ACT_EXPIRED   = 3'd5;
	localparam logic [2:0] ACT_TICK_DONE = 3'd6;

	// reported status codes with a meaning of their own
	localparam logic [2:0] STATUS_JOIN    = 3'd0;
	localparam logic [2:0] STATUS_OFFLINE = 3'd6;

	// input kinds
	localparam logic KIND_MSG  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [2:0]      action;
		logic [ID_W-1:0] entry_id;
		logic [3:0]      slot;
		logic [2:0]      echo_status;
		logic [4:0]      live_count;
		logic            last;
	} res_t;

endpackage
`default_nettype wire

// ----- design/heartbeat_presence_table.sv -----
// Heartbeat presence table: top level with input handshake and output register.
// Usage:
//   Input channel (in_valid/in_ready) carries one request: a status message
//   (kind 0) with sender_id and status, or a time tick (kind 1). in_ready is
//   high only while the sequencer is idle; one request is processed at a time.
//   Output channel (out_valid/out_ready) carries results; a message gives one
//   result, a tick gives one result per expired entry and a closing tick-done
//   result. last marks the final result of a request.
//   Steps: a message searches the table entry by entry, shifts the later
//   entries down one slot on a removal, then hands its result over; the
//   next request is taken once that result has been handed over.
//   A tick scans the entries in slot order; each expiry shifts the later
//   entries down, emits an expired result and resumes the scan at the freed
//   slot, and the closing result follows the scan. The work is serial: the
//   table memory is read one entry a cycle, through the one shared compare.
//   A one-entry output register holds a result while the receiver stalls; the
//   sequencer holds its next result while the register is full and not read.
//   cfg_we/cfg_wdata write the timeout in ticks; write only while idle.
//   Reset empties the table, clears the time counter and sets the timeout to 35.
`default_nettype none
module heartbeat_presence_table
	import hpt_pkg::*;
#(
	parameter int MAX_ENTRIES = HPT_MAX_ENTRIES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             kind,
	input  wire logic [ID_W-1:0]  sender_id,
	input  wire logic [2:0]       status,
	input  wire logic             cfg_we,
	input  wire logic [TMO_W-1:0] cfg_wdata,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [2:0]            action,
	output logic [ID_W-1:0]       entry_id,
	output logic [3:0]            slot,
	output logic [2:0]            echo_status,
	output logic [4:0]            live_count,
	output logic                  last
);

	logic res_valid;
	logic res_ready;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	hpt_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.sender_id (sender_id),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = out_q.action;
	assign entry_id    = out_q.entry_id;
	assign slot        = out_q.slot;
	assign echo_status = out_q.echo_status;
	assign live_count  = out_q.live_count;
	assign last        = out_q.last;

endmodule
`default_nettype wire

// ----- design/hpt_cmp.sv -----
// Shared compare unit: sender match on lookups, age check on sweeps.
`default_nettype none
module hpt_cmp
	import hpt_pkg::*;
(
	input  wire logic               sweep,
	input  wire entry_t             entry,
	input  wire logic [ID_W-1:0]    key,
	input  wire logic [STAMP_W-1:0] now,
	input  wire logic [TMO_W-1:0]   timeout,
	output logic                    hit
);

	logic [STAMP_W-1:0] age;

	// age wraps modulo 2^32
	assign age = now - entry.stamp;

	always_comb begin
		if (sweep) begin
			hit = age > STAMP_W'(timeout);
		end else begin
			hit = entry.id == key;
		end
	end

endmodule
`default_nettype wire

// ----- design/hpt_ctrl.sv -----
// Sequencer and table memory: lookup, append, compaction and expiry sweep.
`default_nettype none
module hpt_ctrl
	import hpt_pkg::*;
#(
	parameter int MAX_ENTRIES = HPT_MAX_ENTRIES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             kind,
	input  wire logic [ID_W-1:0]  sender_id,
	input  wire logic [2:0]       status,
	input  wire logic             cfg_we,
	input  wire logic [TMO_W-1:0] cfg_wdata,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output res_t                  res
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]         state_q;
	logic               kind_q;
	logic [ID_W-1:0]    key_q;
	logic [2:0]         status_q;
	logic [CW-1:0]      count_q;
	logic [STAMP_W-1:0] now_q;
	logic [TMO_W-1:0]   timeout_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      j_q;
	logic [ID_W-1:0]    gone_q;

	logic [2:0]         res_act_q;
	logic [ID_W-1:0]    res_id_q;
	logic [CW-1:0]      res_slot_q;
	logic [2:0]         res_st_q;
	logic               res_last_q;
	logic               resume_q;

	entry_t             mem_q [MAX_ENTRIES];
	entry_t             rdata_q;

	logic [IW-1:0]      rd_addr;
	logic               mem_we;
	logic [IW-1:0]      mem_wa;
	entry_t             mem_wd;

	logic               cmp_hit;
	logic [CW-1:0]      idx_nx;
	logic [CW:0]        j_p2;
	logic               in_range;
	logic               more;
	logic [31:0]        cnt_w;
	logic [31:0]        slot_w;

	assign idx_nx   = idx_q + 1'b1;
	assign j_p2     = {1'b0, j_q} + (CW+1)'(2);
	assign in_range = idx_q < count_q;
	assign more     = idx_nx < count_q;

	// shared compare unit
	hpt_cmp u_cmp (
		.sweep   (kind_q),
		.entry   (rdata_q),
		.key     (key_q),
		.now     (now_q),
		.timeout (timeout_q),
		.hit     (cmp_hit)
	);

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rdata_q <= mem_q[rd_addr];
	end

	// memory address and write control
	always_comb begin
		rd_addr = idx_q[IW-1:0];
		mem_we  = 1'b0;
		mem_wa  = idx_q[IW-1:0];
		mem_wd  = '{id: key_q, stamp: now_q};
		case (state_q)
			ST_IDLE: begin
				rd_addr = '0;
			end
			ST_LOOK: begin
				rd_addr = idx_nx[IW-1:0];
				if (in_range && cmp_hit) begin
					if (status_q != STATUS_OFFLINE) begin
						mem_we = 1'b1;
					end
				end else if (!(in_range && more) && status_q == STATUS_JOIN &&
					count_q < CNT_MAX) begin
					mem_we = 1'b1;
					mem_wa = count_q[IW-1:0];
				end
			end
			ST_SHIFT: begin
				mem_we  = 1'b1;
				mem_wa  = j_q[IW-1:0];
				mem_wd  = rdata_q;
				rd_addr = j_p2[IW-1:0];
			end
			ST_SCAN: begin
				rd_addr = idx_nx[IW-1:0];
			end
			default: begin
				rd_addr = idx_q[IW-1:0];
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			now_q     <= '0;
			timeout_q <= TIMEOUT_RESET;
			idx_q     <= '0;
			j_q       <= '0;
			kind_q    <= KIND_MSG;
			resume_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						kind_q   <= kind;
						key_q    <= sender_id;
						status_q <= status;
						idx_q    <= '0;
						if (kind == KIND_TICK) begin
							now_q   <= now_q + 1'b1;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					res_id_q   <= key_q;
					res_st_q   <= status_q;
					res_last_q <= 1'b1;
					resume_q   <= 1'b0;
					res_slot_q <= '0;
					if (in_range && cmp_hit) begin
						res_slot_q <= idx_q;
						if (status_q == STATUS_OFFLINE) begin
							res_act_q <= ACT_REMOVED;
							if (more) begin
								j_q     <= idx_q;
								state_q <= ST_SHIFT;
							end else begin
								count_q <= count_q - 1'b1;
								state_q <= ST_EMIT;
							end
						end else begin
							res_act_q <= ACT_REFRESHED;
							state_q   <= ST_EMIT;
						end
					end else if (in_range && more) begin
						idx_q <= idx_nx;
					end else begin
						state_q <= ST_EMIT;
						if (status_q != STATUS_JOIN) begin
							res_act_q <= ACT_IGNORED;
						end else if (count_q >= CNT_MAX) begin
							res_act_q <= ACT_REFUSED;
						end else begin
							res_act_q  <= ACT_ADDED;
							res_slot_q <= count_q;
							count_q    <= count_q + 1'b1;
						end
					end
				end
				ST_SHIFT: begin
					// entry j takes entry j+1, read in the previous cycle
					if (j_p2 < {1'b0, count_q}) begin
						j_q <= j_q + 1'b1;
					end else begin
						count_q    <= count_q - 1'b1;
						res_slot_q <= idx_q;
						state_q    <= ST_EMIT;
						if (kind_q == KIND_TICK) begin
							res_act_q  <= ACT_EXPIRED;
							res_id_q   <= gone_q;
							res_st_q   <= '0;
							res_last_q <= 1'b0;
							resume_q   <= 1'b1;
						end else begin
							res_act_q  <= ACT_REMOVED;
							res_id_q   <= key_q;
							res_st_q   <= status_q;
							res_last_q <= 1'b1;
							resume_q   <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					res_st_q <= '0;
					if (!in_range) begin
						res_act_q  <= ACT_TICK_DONE;
						res_id_q   <= '0;
						res_slot_q <= '0;
						res_last_q <= 1'b1;
						resume_q   <= 1'b0;
						state_q    <= ST_EMIT;
					end else if (cmp_hit) begin
						gone_q <= rdata_q.id;
						if (more) begin
							j_q     <= idx_q;
							state_q <= ST_SHIFT;
						end else begin
							count_q    <= count_q - 1'b1;
							res_act_q  <= ACT_EXPIRED;
							res_id_q   <= rdata_q.id;
							res_slot_q <= idx_q;
							res_last_q <= 1'b0;
							resume_q   <= 1'b1;
							state_q    <= ST_EMIT;
						end
					end else begin
						idx_q <= idx_nx;
					end
				end
				ST_EMIT: begin
					// after an expiry the entry now in the freed slot is read again
					if (res_ready) begin
						state_q <= resume_q ? ST_SCAN : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign res_valid = state_q == ST_EMIT;
	assign cnt_w     = 32'(count_q);
	assign slot_w    = 32'(res_slot_q);

	always_comb begin
		res.action      = res_act_q;
		res.entry_id    = res_id_q;
		res.slot        = slot_w[3:0];
		res.echo_status = res_st_q;
		res.live_count  = cnt_w[4:0];
		res.last        = res_last_q;
	end

	// checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count above capacity");

	a_shift_src: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> ({1'b0, j_q} + (CW+1)'(1)) < {1'b0, count_q})
		else $error("compaction source beyond live entries");

	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> $stable(count_q))
		else $error("count changed on accept");

	a_tick_now: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_TICK |=> now_q == $past(now_q) + 1'b1)
		else $error("tick did not advance time by one");

	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind_q == KIND_TICK |-> res_last_q == (res_act_q == ACT_TICK_DONE))
		else $error("tick result last flag wrong");

endmodule
`default_nettype wire

// ----- bench/heartbeat_presence_table_tb.sv -----
// Self-checking bench for the heartbeat presence table: lookup, join, removal and tick sweeps.
`timescale 1ns / 1ps
module heartbeat_presence_table_tb;
	import hpt_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int POOL_SIZE    = 24;
	localparam int PRINT_LIMIT  = 40;
	localparam logic [ID_W-1:0]  ID_ALL_ONES  = '1;
	localparam logic [TMO_W-1:0] TMO_LONGEST  = '1;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	logic             kind      = KIND_MSG;
	logic [ID_W-1:0]  sender_id = '0;
	logic [2:0]       status    = STATUS_JOIN;
	logic             cfg_we    = 1'b0;
	logic [TMO_W-1:0] cfg_wdata = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       action;
	logic [ID_W-1:0]  entry_id;
	logic [3:0]       slot;
	logic [2:0]       echo_status;
	logic [4:0]       live_count;
	logic             last;

	// shadow copy of the presence table
	logic [ID_W-1:0]    tbl_ids [HPT_MAX_ENTRIES];
	logic [STAMP_W-1:0] tbl_stamps [HPT_MAX_ENTRIES];
	int                 tbl_count   = 0;
	logic [STAMP_W-1:0] tick_now    = '0;
	logic [TMO_W-1:0]   timeout_val = TIMEOUT_RESET;

	// results owed by the block, oldest first
	res_t presence_reports [$];
	res_t want;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_start     = 0;
	int hold_left      = 0;
	int cycle_count    = 0;
	int error_count    = 0;
	int requests_sent  = 0;
	int ticks_sent     = 0;
	int results_seen   = 0;
	int act_seen [8];

	heartbeat_presence_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.sender_id   (sender_id),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.action      (action),
		.entry_id    (entry_id),
		.slot        (slot),
		.echo_status (echo_status),
		.live_count  (live_count),
		.last        (last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// table prediction
	// ------------------------------------------------------------------
	function automatic void push_report(logic [2:0] act, logic [ID_W-1:0] id, int pos,
			logic [2:0] st, logic fin);
		res_t r;
		r.action      = act;
		r.entry_id    = id;
		r.slot        = 4'(pos);
		r.echo_status = st;
		r.live_count  = 5'(tbl_count);
		r.last        = fin;
		presence_reports.push_back(r);
	endfunction

	// compact the table over a freed slot
	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < tbl_count; i++) begin
			tbl_ids[i]    = tbl_ids[i + 1];
			tbl_stamps[i] = tbl_stamps[i + 1];
		end
		if (tbl_count > 0) begin
			tbl_count--;
		end
	endfunction

	function automatic void track_presence(logic k, logic [ID_W-1:0] id, logic [2:0] st);
		int                 hit;
		int                 i;
		logic [STAMP_W-1:0] age;
		logic [ID_W-1:0]    gone;
		hit = -1;
		if (k == KIND_MSG) begin
			for (i = 0; i < tbl_count; i++) begin
				if (hit < 0 && tbl_ids[i] == id) begin
					hit = i;
				end
			end
			if (hit >= 0) begin
				if (st == STATUS_OFFLINE) begin
					drop_entry(hit);
					push_report(ACT_REMOVED, id, hit, st, 1'b1);
				end else begin
					tbl_stamps[hit] = tick_now;
					push_report(ACT_REFRESHED, id, hit, st, 1'b1);
				end
			end else if (st != STATUS_JOIN) begin
				push_report(ACT_IGNORED, id, 0, st, 1'b1);
			end else if (tbl_count >= HPT_MAX_ENTRIES) begin
				push_report(ACT_REFUSED, id, 0, st, 1'b1);
			end else begin
				tbl_ids[tbl_count]    = id;
				tbl_stamps[tbl_count] = tick_now;
				tbl_count++;
				push_report(ACT_ADDED, id, tbl_count - 1, st, 1'b1);
			end
		end else begin
			// sweep in slot order; a removal pulls the next entry into the same slot
			tick_now = tick_now + 1;
			i = 0;
			while (i < tbl_count) begin
				age = tick_now - tbl_stamps[i];
				if (age > {16'd0, timeout_val}) begin
					gone = tbl_ids[i];
					drop_entry(i);
					push_report(ACT_EXPIRED, gone, i, 3'd0, 1'b0);
				end else begin
					i++;
				end
			end
			push_report(ACT_TICK_DONE, '0, 0, 3'd0, 1'b1);
		end
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT) begin
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		end
		error_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned exp_val);
		if (got != exp_val) begin
			report_mismatch($sformatf("%s is %0d, should be %0d (result %0d)",
				name, got, exp_val, results_seen));
		end
	endtask

	// result monitor and run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run exceeded %0d cycles with %0d results owed", CYCLE_LIMIT,
				presence_reports.size());
			$display("TB_ERROR");
			$finish;
		end else if (arst_n && out_valid && out_ready) begin
			act_seen[action]++;
			if (presence_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected result, action %0d id %0h",
					action, entry_id));
			end else begin
				want = presence_reports.pop_front();
				check_field("action", action, want.action);
				check_field("entry_id", entry_id, want.entry_id);
				check_field("slot", slot, want.slot);
				check_field("echo_status", echo_status, want.echo_status);
				check_field("live_count", live_count, want.live_count);
				check_field("last", last, want.last);
			end
			results_seen++;
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_start > 0) begin
			hold_left  = hold_start;
			hold_start = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	// offer one request and wait for the handshake; called and left at a falling edge
	task automatic send_request(input logic k, input logic [ID_W-1:0] id, input logic [2:0] st);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		sender_id <= id;
		status    <= st;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_presence(k, id, st);
		requests_sent++;
		if (k == KIND_TICK) begin
			ticks_sent++;
		end
		@(negedge clk);
	endtask

	// stop offering, collect every owed result, then let the sequencer settle
	task automatic settle();
		in_valid <= 1'b0;
		while (presence_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_timeout(input logic [TMO_W-1:0] ticks);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= ticks;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
		timeout_val = ticks;
	endtask

	task automatic hold_receiver(input int cycles);
		@(posedge clk);
		hold_start = cycles;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// joins, refreshes, removal and ignored senders at the reset timeout
	task automatic test_message_cases();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		// tick on an empty table; message fields must not matter
		send_request(KIND_TICK, ID_ALL_ONES, 3'd7);
		send_request(KIND_MSG, '0, STATUS_JOIN);
		send_request(KIND_MSG, ID_ALL_ONES, STATUS_JOIN);
		send_request(KIND_MSG, 22'h15A5A5, STATUS_JOIN);
		send_request(KIND_MSG, '0, 3'd3);
		send_request(KIND_MSG, ID_ALL_ONES, 3'd7);
		send_request(KIND_MSG, 22'h15A5A5, 3'd2);
		// join from a sender already present only refreshes it
		send_request(KIND_MSG, '0, STATUS_JOIN);
		// unknown sender going offline leaves the count alone
		send_request(KIND_MSG, 22'h2AAAAA, STATUS_OFFLINE);
		send_request(KIND_MSG, 22'h2AAAAA, 3'd5);
		send_request(KIND_MSG, 22'h000001, 3'd4);
		send_request(KIND_MSG, 22'h000001, 3'd1);
		// removing slot 0 shifts the rest down
		send_request(KIND_MSG, '0, STATUS_OFFLINE);
		send_request(KIND_MSG, 22'h15A5A5, 3'd1);
	endtask

	// sweeps with zero and one tick of timeout
	task automatic test_expiry_sweep();
		set_timeout('0);
		send_request(KIND_MSG, '0, STATUS_JOIN);
		// every entry expires, each one pulled into slot 0 in turn
		send_request(KIND_TICK, '0, 3'd0);
		set_timeout(16'd1);
		send_request(KIND_MSG, 22'h000001, STATUS_JOIN);
		send_request(KIND_TICK, '0, 3'd0);
		send_request(KIND_MSG, 22'h000002, STATUS_JOIN);
		send_request(KIND_TICK, '0, 3'd0);
		send_request(KIND_MSG, 22'h000002, 3'd5);
		send_request(KIND_TICK, '0, 3'd0);
		send_request(KIND_TICK, '0, 3'd0);
	endtask

	// fill the table behind a stalled receiver, then expire all of it at once
	task automatic test_backpressure_fill();
		logic [ID_W-1:0] base;
		set_timeout(TMO_LONGEST);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		base = ID_W'($urandom());
		hold_receiver(300);
		for (int k = 0; k < HPT_MAX_ENTRIES + 4; k++) begin
			send_request(KIND_MSG, base + ID_W'(k), STATUS_JOIN);
		end
		set_timeout('0);
		hold_receiver(150);
		send_request(KIND_TICK, base, 3'd7);
	endtask

	// one phase of random traffic over a small pool of senders
	task automatic run_traffic(input int items, input int idle_p, input int stall_p,
			input int tick_p, input logic [TMO_W-1:0] ticks);
		logic [ID_W-1:0] pool [POOL_SIZE];
		logic [2:0]      st;
		int              roll;
		set_timeout(ticks);
		src_idle_pct   = idle_p;
		sink_stall_pct = stall_p;
		foreach (pool[j]) begin
			pool[j] = ID_W'($urandom());
		end
		pool[0] = '0;
		pool[1] = ID_ALL_ONES;
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(99);
			if (roll < tick_p) begin
				send_request(KIND_TICK, ID_W'($urandom()), 3'($urandom()));
			end else if (roll < tick_p + 8) begin
				// stray sender, mostly ignored
				send_request(KIND_MSG, ID_W'($urandom()), 3'($urandom()));
			end else begin
				roll = $urandom_range(99);
				if (roll < 45) begin
					st = STATUS_JOIN;
				end else if (roll < 60) begin
					st = STATUS_OFFLINE;
				end else begin
					st = 3'($urandom_range(7));
				end
				send_request(KIND_MSG, pool[$urandom_range(POOL_SIZE - 1)], st);
			end
		end
	endtask

	// the tick counter cannot wrap within any practical run, so ages stay small here
	task automatic test_random_traffic();
		run_traffic(90, 0, 0, 15, 16'd3);
		run_traffic(90, 61, 0, 10, 16'd1);
		run_traffic(90, 0, 61, 5, TMO_LONGEST);
		run_traffic(90, 33, 33, 20, 16'd7);
	endtask

	initial begin
		foreach (act_seen[a]) begin
			act_seen[a] = 0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_message_cases();
		test_expiry_sweep();
		test_backpressure_fill();
		test_random_traffic();
		settle();

		$display("Covered %0d requests (%0d ticks), %0d results checked.",
			requests_sent, ticks_sent, results_seen);
		$display("Seen: %0d adds, %0d refusals, %0d removals, %0d expiries, %0d ignored.",
			act_seen[ACT_ADDED], act_seen[ACT_REFUSED], act_seen[ACT_REMOVED],
			act_seen[ACT_EXPIRED], act_seen[ACT_IGNORED]);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
